// ===== rtl/hrhe_pkg.sv =====
// Package for the hex record halfword extractor.
// Holds the queue entry type, record layout constants and the digit decoder.
// Has no dependencies; every other file of the block uses it.
package hrhe_pkg;

	// Record layout: count digits, offset digits and first data digit.
	localparam logic [9:0] POS_COUNT_HI  = 10'd1;
	localparam logic [9:0] POS_COUNT_LO  = 10'd2;
	localparam logic [9:0] POS_OFFS_FIRST = 10'd3;
	localparam logic [9:0] POS_OFFS_LAST  = 10'd6;
	localparam logic [9:0] POS_DATA      = 10'd9;
	localparam logic [9:0] POS_MAX       = 10'd1023;

	// Digit position within a four-digit group.
	localparam logic [1:0] DIGIT_FIRST = 2'd0;
	localparam logic [1:0] DIGIT_LAST  = 2'd3;

	// Reset value of the base address register.
	localparam logic [31:0] FLASH_BASE_RESET = 32'h0800_0000;

	// One completed halfword, as it waits between front and back.
	typedef struct packed {
		logic [15:0] offset;
		logic [6:0]  word_index;
		logic [15:0] halfword;
		logic        last_word;
	} word_t;

	// Maps an ASCII hex digit (0-9, A-F) to its value; anything else, lowercase included, gives zero.
	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [3:0] n;
		n = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			n = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			n = 4'(c - 8'h41 + 8'd10);
		end
		return n;
	endfunction

endpackage

// ===== rtl/hrhe_front.sv =====
// Front part of the extractor: accepts characters and tracks the record.
// Decodes count and offset and assembles halfwords; depends on hrhe_pkg.
module hrhe_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] ch
	input  logic               s_tlast,   // last_char
	input  logic               q_full,
	output logic               push,
	output hrhe_pkg::word_t    push_word
);

	logic [9:0]  pos_q;
	logic [7:0]  count_q;
	logic [15:0] offset_q;
	logic [11:0] acc_q;

	logic        accept;
	logic [3:0]  nib;
	logic [9:0]  k;
	logic [7:0]  group;
	logic [1:0]  digit;
	logic [6:0]  groups;
	logic        in_data;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign nib      = hrhe_pkg::nibble_of(s_tdata);

	// Place of the current character within the data groups.
	assign k       = pos_q - hrhe_pkg::POS_DATA;
	assign group   = k[9:2];
	assign digit   = k[1:0];
	assign groups  = count_q[7:1];
	assign in_data = (pos_q >= hrhe_pkg::POS_DATA) && (group < {1'b0, groups});

	// A halfword is complete on the fourth digit of a counted group.
	assign push = accept && in_data && (digit == hrhe_pkg::DIGIT_LAST);

	always_comb begin
		push_word.offset     = offset_q;
		push_word.word_index = group[6:0];
		push_word.halfword   = {acc_q, nib};
		push_word.last_word  = (group[6:0] == groups - 7'd1);
	end

	// Record state; a final character clears everything for the next record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			count_q  <= '0;
			offset_q <= '0;
			acc_q    <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				pos_q    <= '0;
				count_q  <= '0;
				offset_q <= '0;
				acc_q    <= '0;
			end else begin
				if (pos_q == hrhe_pkg::POS_COUNT_HI || pos_q == hrhe_pkg::POS_COUNT_LO) begin
					count_q <= {count_q[3:0], nib};
				end else if (pos_q >= hrhe_pkg::POS_OFFS_FIRST &&
						pos_q <= hrhe_pkg::POS_OFFS_LAST) begin
					offset_q <= {offset_q[11:0], nib};
				end else if (in_data) begin
					if (digit == hrhe_pkg::DIGIT_FIRST) begin
						acc_q <= {8'd0, nib};
					end else if (digit == hrhe_pkg::DIGIT_LAST) begin
						acc_q <= '0;
					end else begin
						acc_q <= {acc_q[7:0], nib};
					end
				end
				if (pos_q != hrhe_pkg::POS_MAX) begin
					pos_q <= pos_q + 10'd1;
				end
			end
		end
	end

endmodule

// ===== rtl/hrhe_queue.sv =====
// Short queue of completed halfwords between front and back.
// Circular buffer with a fill count; depends on hrhe_pkg for the entry type.
module hrhe_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hrhe_pkg::word_t    push_word,
	input  logic               pop,
	output logic               full,
	output logic               not_empty,
	output hrhe_pkg::word_t    head_word
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	hrhe_pkg::word_t mem [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head_word = mem[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_word;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/hrhe_back.sv =====
// Back part of the extractor: holds the base register and the output stage.
// Forms the record address and presents results; depends on hrhe_pkg.
module hrhe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data,
	input  logic               q_not_empty,
	input  hrhe_pkg::word_t    q_word,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [55:0]        m_tdata,   // [31:0] record_address, [38:32] word_index,
	                                      // [54:39] halfword, [55] zero
	output logic               m_tlast    // last_word
);

	logic [31:0] flash_base_q;
	logic        valid_q;
	logic [31:0] addr_q;
	logic [6:0]  index_q;
	logic [15:0] half_q;
	logic        last_q;

	assign cfg_ready = 1'b1;

	// Base address register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_base_q <= hrhe_pkg::FLASH_BASE_RESET;
		end else if (cfg_valid) begin
			flash_base_q <= cfg_data;
		end
	end

	// Load the output stage whenever it is empty or being drained.
	assign pop = q_not_empty && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || m_tready) begin
			valid_q <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			addr_q  <= {16'd0, q_word.offset} | flash_base_q;
			index_q <= q_word.word_index;
			half_q  <= q_word.halfword;
			last_q  <= q_word.last_word;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, half_q, index_q, addr_q};
	assign m_tlast  = last_q;

endmodule

// ===== rtl/hex_record_halfword_extractor.sv =====
// Hex record halfword extractor, top level.
// Input stream s_*: one ASCII character per transaction, colon first; s_tlast
// marks the last character of a record, after which a new record begins.
// Characters 1-2 give the byte count, 3-6 the offset, and from character 9
// each group of four hex digits becomes one halfword, for count/2 groups.
// Output stream m_*: one transaction per halfword with the record address
// (offset ORed with the base register), its index and the halfword; m_tlast
// marks the last halfword of the record.
// Configuration: cfg_valid/cfg_data write the 32-bit base register, which is
// always ready; write it only while no record is in flight.
// Throughput: one character per cycle while the queue is not full. A halfword
// reaches m_* through the queue write and then the output register load once
// the character that completes it is taken. Reset clears the record state, the
// queue and the output stage, and sets the base to 0x08000000.
// When the receiver stalls, results wait in the output register and the
// queue; s_tready drops only once the queue is full.
module hex_record_halfword_extractor #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] ch
	input  logic        s_tlast,    // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,    // [31:0] record_address, [38:32] word_index,
	                                // [54:39] halfword, [55] zero
	output logic        m_tlast,    // last_word
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic            q_full;
	logic            q_not_empty;
	logic            push;
	logic            pop;
	hrhe_pkg::word_t push_word;
	hrhe_pkg::word_t head_word;

	// Character intake and record tracking.
	hrhe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.push      (push),
		.push_word (push_word)
	);

	// Decoupling queue.
	hrhe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_word (head_word)
	);

	// Address forming and output stage.
	hrhe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.q_not_empty (q_not_empty),
		.q_word      (head_word),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule
